// ----- src/pdfcte_pkg.sv -----
package pdfcte_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_STRING = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_TOP    = 2'd3
    } parse_mode_t;

    typedef enum logic [2:0] {
        STK_NONE,
        STK_PUSH,
        STK_WRITE,
        STK_POP1,
        STK_POPTM
    } stk_op_t;

    typedef struct packed {
        logic    clear;
        stk_op_t op;
        logic    value;
    } stk_cmd_t;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // operands dropped by the Tm operator
    localparam int TM_POP_COUNT = 6;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_D = 8'h44;
    localparam logic [7:0] CH_UPPER_T = 8'h54;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_LOWER_M = 8'h6D;

endpackage

// ----- src/pdfcte_stack.sv -----
module pdfcte_stack #(
    parameter int STACK_DEPTH = 32,
    parameter int PTR_W       = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 enable,
    input  pdfcte_pkg::stk_cmd_t cmd,
    output logic                 top_flag,
    output logic [PTR_W-1:0]     stack_ptr
);
    import pdfcte_pkg::*;

    localparam int TM_STEP = TM_POP_COUNT % STACK_DEPTH;

    logic [STACK_DEPTH-1:0] stack_reg, stack_next;
    logic [PTR_W-1:0]       sp_reg, sp_next;
    logic [PTR_W-1:0]       sp_inc, sp_dec, sp_dec_tm;

    assign sp_inc = (sp_reg == PTR_W'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec = (sp_reg == '0) ? PTR_W'(STACK_DEPTH - 1) : sp_reg - 1'b1;
    assign sp_dec_tm = (sp_reg >= PTR_W'(TM_STEP)) ? sp_reg - PTR_W'(TM_STEP)
                                                   : sp_reg + PTR_W'(STACK_DEPTH - TM_STEP);

    // value that a pop would return
    assign top_flag  = stack_reg[sp_dec];
    assign stack_ptr = sp_reg;

    always_comb
    begin
        stack_next = stack_reg;
        sp_next    = sp_reg;
        if (enable)
        begin
            if (cmd.clear)
            begin
                stack_next = '0;
                sp_next    = '0;
            end
            else
            begin
                unique case (cmd.op)
                    STK_PUSH:
                    begin
                        stack_next[sp_reg] = cmd.value;
                        sp_next            = sp_inc;
                    end
                    // push and pop at once inside an array
                    STK_WRITE:
                    begin
                        stack_next[sp_reg] = cmd.value;
                    end
                    STK_POP1:  sp_next = sp_dec;
                    STK_POPTM: sp_next = sp_dec_tm;
                    default:   sp_next = sp_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_reg <= '0;
            sp_reg    <= '0;
        end
        else
        begin
            stack_reg <= stack_next;
            sp_reg    <= sp_next;
        end
    end

endmodule

// ----- src/pdfcte_parser.sv -----
module pdfcte_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 enable,
    input  logic                 command,
    input  logic [7:0]           data_byte,
    input  logic                 top_flag,
    output logic                 emit,
    output logic [7:0]           emit_byte,
    output pdfcte_pkg::stk_cmd_t stk_cmd
);
    import pdfcte_pkg::*;

    parse_mode_t mode_reg, mode_next;
    logic        array_reg, array_next;
    logic        seen_dot_reg, seen_dot_next;
    logic        prefix_done_reg, prefix_done_next;
    logic        nonzero_reg, nonzero_next;

    logic        is_space, is_digit, is_nz_digit;
    parse_mode_t nb_mode;
    logic        nb_array;
    logic        nb_emit;

    assign is_space = (data_byte == CH_SPACE) || (data_byte >= CH_TAB && data_byte <= CH_CR);
    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign is_nz_digit = is_digit && (data_byte != CH_ZERO);

    // handling of a byte in normal mode, shared with the byte that ends a number
    always_comb
    begin
        nb_mode  = MODE_NORMAL;
        nb_array = array_reg;
        nb_emit  = 1'b0;
        priority if (is_space)
        begin
            nb_mode = MODE_NORMAL;
        end
        else if (data_byte == CH_LBRACK)
        begin
            nb_array = 1'b1;
        end
        else if (data_byte == CH_RBRACK)
        begin
            nb_array = 1'b0;
        end
        else if (data_byte == CH_LPAREN)
        begin
            nb_mode = MODE_STRING;
        end
        else if (is_digit || data_byte == CH_MINUS)
        begin
            nb_mode = MODE_NUMBER;
        end
        else if (data_byte == CH_UPPER_T)
        begin
            nb_mode = MODE_TOP;
        end
        else if (data_byte == CH_QUOTE || data_byte == CH_DQUOTE)
        begin
            nb_emit = 1'b1;
        end
        else
        begin
            nb_mode = MODE_NORMAL;
        end
    end

    // next state
    always_comb
    begin
        mode_next        = mode_reg;
        array_next       = array_reg;
        seen_dot_next    = seen_dot_reg;
        prefix_done_next = prefix_done_reg;
        nonzero_next     = nonzero_reg;
        if (command == CMD_START)
        begin
            mode_next        = MODE_NORMAL;
            array_next       = 1'b0;
            seen_dot_next    = 1'b0;
            prefix_done_next = 1'b0;
            nonzero_next     = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_STRING:
                begin
                    if (data_byte == CH_RPAREN)
                        mode_next = MODE_NORMAL;
                end
                MODE_NUMBER:
                begin
                    priority if (is_digit)
                    begin
                        if (!prefix_done_reg && is_nz_digit)
                            nonzero_next = 1'b1;
                    end
                    else if (data_byte == CH_DOT)
                    begin
                        if (seen_dot_reg)
                            prefix_done_next = 1'b1;
                        else
                            seen_dot_next = 1'b1;
                    end
                    else if (data_byte == CH_MINUS)
                    begin
                        prefix_done_next = 1'b1;
                    end
                    else
                    begin
                        mode_next  = nb_mode;
                        array_next = nb_array;
                    end
                end
                MODE_TOP:
                begin
                    mode_next = MODE_NORMAL;
                end
                MODE_NORMAL:
                begin
                    mode_next  = nb_mode;
                    array_next = nb_array;
                    if (nb_mode == MODE_NUMBER)
                    begin
                        seen_dot_next    = 1'b0;
                        prefix_done_next = 1'b0;
                        nonzero_next     = is_nz_digit;
                    end
                end
                default: mode_next = MODE_NORMAL;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        emit          = 1'b0;
        emit_byte     = CH_LF;
        stk_cmd.clear = (command == CMD_START);
        stk_cmd.op    = STK_NONE;
        stk_cmd.value = nonzero_reg;
        if (command == CMD_DATA)
        begin
            unique case (mode_reg)
                MODE_STRING:
                begin
                    emit      = (data_byte != CH_RPAREN);
                    emit_byte = data_byte;
                end
                MODE_NUMBER:
                begin
                    if (!is_digit && data_byte != CH_DOT && data_byte != CH_MINUS)
                    begin
                        stk_cmd.op = array_reg ? STK_WRITE : STK_PUSH;
                        emit       = nb_emit;
                    end
                end
                MODE_TOP:
                begin
                    priority if (data_byte == CH_STAR)
                    begin
                        emit = 1'b1;
                    end
                    else if (data_byte == CH_UPPER_D || data_byte == CH_LOWER_D)
                    begin
                        stk_cmd.op = STK_POP1;
                        emit       = top_flag;
                    end
                    else if (data_byte == CH_LOWER_M)
                    begin
                        stk_cmd.op = STK_POPTM;
                    end
                    else
                    begin
                        stk_cmd.op = STK_POP1;
                    end
                end
                MODE_NORMAL:
                begin
                    emit = nb_emit;
                end
                default: emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_NORMAL;
            array_reg       <= 1'b0;
            seen_dot_reg    <= 1'b0;
            prefix_done_reg <= 1'b0;
            nonzero_reg     <= 1'b0;
        end
        else if (enable)
        begin
            mode_reg        <= mode_next;
            array_reg       <= array_next;
            seen_dot_reg    <= seen_dot_next;
            prefix_done_reg <= prefix_done_next;
            nonzero_reg     <= nonzero_next;
        end
    end

endmodule

// ----- src/pdf_content_text_extractor_unit.sv -----
// channel  dir  tdata                 tuser
// s_axis   in   [7:0] data_byte       [0] command (1 = start of stream)
// m_axis   out  [7:0] text_byte       -
//
// One word per cycle sustained while m_axis is not stalled. A word is registered
// on input, decoded against the parser state and the stack, and any text byte
// lands in the output register. Reset clears parser state, the stack and the
// pointer at once; a start command does the same. A stall on m_axis holds the
// output word, and s_axis keeps taking words while the input register is free or
// draining.
module pdf_content_text_extractor_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] command
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] text_byte
);
    import pdfcte_pkg::*;

    localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic       in_valid_reg, in_valid_next;
    logic       in_cmd_reg, in_cmd_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;

    logic       advance;
    logic       s_accept;
    logic       emit;
    logic [7:0] emit_byte;
    logic       top_flag;
    stk_cmd_t   stk_cmd;
    logic [PTR_W-1:0] stack_ptr;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;

    pdfcte_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (advance),
        .command   (in_cmd_reg),
        .data_byte (in_byte_reg),
        .top_flag  (top_flag),
        .emit      (emit),
        .emit_byte (emit_byte),
        .stk_cmd   (stk_cmd)
    );

    pdfcte_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .PTR_W       (PTR_W)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (advance),
        .cmd       (stk_cmd),
        .top_flag  (top_flag),
        .stack_ptr (stack_ptr)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_cmd_next   = in_cmd_reg;
        in_byte_next  = in_byte_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
            in_cmd_next   = s_axis_tuser;
            in_byte_next  = s_axis_tdata;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        if (advance)
        begin
            out_valid_next = emit;
            out_byte_next  = emit_byte;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_cmd_reg   <= in_cmd_next;
        in_byte_reg  <= in_byte_next;
        out_byte_reg <= out_byte_next;
    end

    a_start_clears_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_cmd_reg == CMD_START |=> stack_ptr == '0)
        else $error("stack pointer not cleared by start command");

    a_start_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_cmd_reg == CMD_START |=> !m_axis_tvalid)
        else $error("start command produced an output word");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(stack_ptr) < STACK_DEPTH)
        else $error("stack pointer out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without a blocked output");

endmodule

// ----- bench/pdf_content_text_extractor_unit_tb.sv -----
`timescale 1ns / 1ps

module pdf_content_text_extractor_unit_tb;

    import pdfcte_pkg::*;

    localparam int OP_DEPTH      = 32;
    localparam int PTR_W         = $clog2(OP_DEPTH);
    localparam int PHASE_WORDS   = 250;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct {
        logic       cmd;
        logic [7:0] data;
        int         phase;
        bit         drain;
    } stream_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       s_axis_tuser = 1'b0;    // [0] command
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] text_byte

    stream_word_t pending[$];
    logic [7:0]   text_expect[$];

    // parser copy kept in step with every accepted word
    parse_mode_t      text_mode;
    bit               array_open;
    bit               op_flags [OP_DEPTH];
    logic [PTR_W-1:0] op_ptr;
    bit               saw_dot;
    bit               prefix_done;
    bit               num_nz;

    int fill_phase = 0;
    bit fill_drain = 1'b0;
    int drive_phase = 0;
    int accepted_words = 0;
    int settle = 0;
    int hold_at = -1;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int mismatches = 0;
    int text_seen = 0;
    int cycles = 0;

    pdf_content_text_extractor_unit #(
        .STACK_DEPTH(OP_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic int idle_pct(bit recv, int phase);
        case (phase)
            0:       return recv ? 52 : 27;
            1:       return recv ? 27 : 52;
            default: return 0;
        endcase
    endfunction

    task automatic clear_parser();
        text_mode   = MODE_NORMAL;
        array_open  = 1'b0;
        op_ptr      = '0;
        saw_dot     = 1'b0;
        prefix_done = 1'b0;
        num_nz      = 1'b0;
        foreach (op_flags[i])
            op_flags[i] = 1'b0;
    endtask

    task automatic push_op(bit v);
        op_flags[op_ptr] = v;
        op_ptr = op_ptr + 1'b1;
    endtask

    function automatic bit pop_op();
        op_ptr = op_ptr - 1'b1;
        return op_flags[op_ptr];
    endfunction

    // returns 1 when the byte is a quote operator and a newline goes out
    function automatic bit plain_byte(logic [7:0] c);
        bit nl;
        nl = 1'b0;
        if (is_blank(c))
            nl = 1'b0;
        else if (c == CH_LBRACK)
            array_open = 1'b1;
        else if (c == CH_RBRACK)
            array_open = 1'b0;
        else if (c == CH_LPAREN)
            text_mode = MODE_STRING;
        else if (is_digit(c) || c == CH_MINUS)
        begin
            text_mode   = MODE_NUMBER;
            saw_dot     = 1'b0;
            prefix_done = 1'b0;
            num_nz      = is_digit(c) && c != CH_ZERO;
        end
        else if (c == CH_UPPER_T)
            text_mode = MODE_TOP;
        else if (c == CH_QUOTE || c == CH_DQUOTE)
            nl = 1'b1;
        return nl;
    endfunction

    task automatic predict_text(logic cmd, logic [7:0] c);
        bit         emit;
        logic [7:0] txt;
        emit = 1'b0;
        txt  = CH_LF;
        if (cmd == CMD_START)
            clear_parser();
        else
        begin
            case (text_mode)
                MODE_STRING:
                    if (c == CH_RPAREN)
                        text_mode = MODE_NORMAL;
                    else
                    begin
                        emit = 1'b1;
                        txt  = c;
                    end
                MODE_NUMBER:
                    if (is_digit(c))
                    begin
                        if (!prefix_done && c != CH_ZERO)
                            num_nz = 1'b1;
                    end
                    else if (c == CH_DOT)
                    begin
                        if (saw_dot)
                            prefix_done = 1'b1;
                        else
                            saw_dot = 1'b1;
                    end
                    else if (c == CH_MINUS)
                        prefix_done = 1'b1;
                    else
                    begin
                        // the closing byte is parsed again as a plain byte
                        push_op(num_nz);
                        if (array_open)
                            void'(pop_op());
                        text_mode = MODE_NORMAL;
                        emit = plain_byte(c);
                    end
                MODE_TOP:
                begin
                    text_mode = MODE_NORMAL;
                    if (c == CH_STAR)
                        emit = 1'b1;
                    else if (c == CH_UPPER_D || c == CH_LOWER_D)
                        emit = pop_op();
                    else if (c == CH_LOWER_M)
                    begin
                        for (int k = 0; k < TM_POP_COUNT; k++)
                            void'(pop_op());
                    end
                    else
                        void'(pop_op());
                end
                default:
                    emit = plain_byte(c);
            endcase
        end
        if (emit)
            text_expect.push_back(txt);
    endtask

    task automatic add_word(logic cmd, logic [7:0] b);
        stream_word_t w;
        w.cmd   = cmd;
        w.data  = b;
        w.phase = fill_phase;
        w.drain = fill_drain;
        fill_drain = 1'b0;
        pending.push_back(w);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_word(CMD_DATA, s[i]);
    endtask

    function automatic logic [7:0] blank_byte();
        if ($urandom_range(0, 2) == 0)
            return CH_SPACE;
        return CH_TAB + 8'($urandom_range(0, 4));
    endfunction

    function automatic logic [7:0] digit_byte();
        if ($urandom_range(0, 2) == 0)
            return CH_ZERO;
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic add_number();
        int n;
        if ($urandom_range(0, 3) == 0)
            add_word(CMD_DATA, CH_MINUS);
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            add_word(CMD_DATA, digit_byte());
        if ($urandom_range(0, 1) == 0)
        begin
            add_word(CMD_DATA, CH_DOT);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                add_word(CMD_DATA, digit_byte());
        end
        // a stray '-' or second '.' closes the numeric prefix
        if ($urandom_range(0, 5) == 0)
        begin
            add_word(CMD_DATA, $urandom_range(0, 1) ? CH_MINUS : CH_DOT);
            add_word(CMD_DATA, digit_byte());
        end
    endtask

    task automatic add_operator();
        logic [7:0] b;
        add_word(CMD_DATA, CH_UPPER_T);
        case ($urandom_range(0, 5))
            0:       b = CH_STAR;
            1:       b = CH_LOWER_D;
            2:       b = CH_UPPER_D;
            3:       b = CH_LOWER_M;
            4:       b = blank_byte();
            default: b = 8'($urandom_range(0, 255));
        endcase
        add_word(CMD_DATA, b);
    endtask

    task automatic add_token();
        int         n;
        logic [7:0] b;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4:
            begin
                add_word(CMD_DATA, CH_LPAREN);
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++)
                begin
                    b = 8'($urandom_range(0, 255));
                    add_word(CMD_DATA, (b == CH_RPAREN) ? ~b : b);
                end
                add_word(CMD_DATA, CH_RPAREN);
            end
            5, 6, 7, 8:
            begin
                add_number();
                case ($urandom_range(0, 3))
                    0:       add_operator();
                    1:       add_word(CMD_DATA, CH_RBRACK);
                    default: add_word(CMD_DATA, blank_byte());
                endcase
            end
            9, 10, 11, 12: add_operator();
            13: add_word(CMD_DATA, $urandom_range(0, 1) ? CH_QUOTE : CH_DQUOTE);
            14: add_word(CMD_DATA, CH_LBRACK);
            15: add_word(CMD_DATA, CH_RBRACK);
            16: add_word(CMD_DATA, blank_byte());
            17: add_word(CMD_DATA, 8'($urandom_range(0, 255)));
            18:
            begin
                // new stream, at times cutting a broken string short
                if ($urandom_range(0, 1) == 0)
                begin
                    add_word(CMD_DATA, CH_LPAREN);
                    add_word(CMD_DATA, 8'($urandom_range(0, 255)));
                end
                add_word(CMD_START, 8'($urandom_range(0, 255)));
            end
            default:
            begin
                add_number();
                add_word(CMD_DATA, blank_byte());
                add_word(CMD_DATA, CH_UPPER_T);
                add_word(CMD_DATA, $urandom_range(0, 1) ? CH_LOWER_D : CH_UPPER_D);
            end
        endcase
    endtask

    initial
    begin
        int base;
        clear_parser();

        fill_phase = 0;
        add_word(CMD_START, 8'hA5);
        add_word(CMD_DATA, CH_LPAREN);
        add_word(CMD_DATA, 8'h00);
        add_word(CMD_DATA, 8'hFF);
        add_text(")T*'\"7Td0.0.7TD[4]1Tm- T (x");
        add_word(CMD_START, 8'h5A);

        for (int p = 0; p < 3; p++)
        begin
            fill_phase = p;
            fill_drain = (p != 0);
            base = pending.size();
            if (p == 2)
                hold_at = base + 60;
            while (pending.size() < base + PHASE_WORDS)
                add_token();
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (text_expect.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && text_expect.size() == 0)
            $display("pdf_content_text_extractor_unit: match");
        else
            $display("pdf_content_text_extractor_unit: mismatch");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic         nv;
        logic [7:0]   nd;
        logic         nu;
        bit           took;
        bit           gated;
        int           ns;
        stream_word_t w;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            nv   = s_axis_tvalid;
            nd   = s_axis_tdata;
            nu   = s_axis_tuser;
            took = s_axis_tvalid && s_axis_tready;
            if (took)
            begin
                predict_text(s_axis_tuser, s_axis_tdata);
                accepted_words <= accepted_words + 1;
                nv = 1'b0;
            end

            if (took || text_expect.size() != 0)
                ns = 0;
            else if (settle < SETTLE_CYCLES)
                ns = settle + 1;
            else
                ns = settle;
            settle <= ns;

            // hold the next phase until the block has drained
            if (!nv && pending.size() != 0)
            begin
                gated = pending[0].drain && (text_expect.size() != 0 || settle < SETTLE_CYCLES);
                if (!gated && $urandom_range(0, 99) >= idle_pct(1'b0, pending[0].phase))
                begin
                    w  = pending.pop_front();
                    nv = 1'b1;
                    nd = w.data;
                    nu = w.cmd;
                    drive_phase <= w.phase;
                end
            end
            s_axis_tvalid <= nv;
            s_axis_tdata  <= nd;
            s_axis_tuser  <= nu;
        end
    end

    // long receiver stall while the sender keeps offering words
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && hold_at >= 0 && accepted_words >= hold_at)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        logic [7:0] want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (text_expect.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("text byte %0d: none expected, got %02h",
                                 text_seen, m_axis_tdata);
                end
                else
                begin
                    want = text_expect.pop_front();
                    if (want !== m_axis_tdata)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("text byte %0d: expected %02h, got %02h",
                                     text_seen, want, m_axis_tdata);
                    end
                end
                text_seen = text_seen + 1;
            end
            m_axis_tready <= (hold_left == 0)
                && ($urandom_range(0, 99) >= idle_pct(1'b1, drive_phase));
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("pdf_content_text_extractor_unit: mismatch");
            $finish;
        end
    end

endmodule
